>>> rtl/fmsq_pkg.sv
// shared types, constants and helpers for the p25519 multiply/square unit
`timescale 1ns / 1ps
package fmsq_pkg;

  localparam int LimbBits  = 51;
  localparam int OpBits    = 55;
  localparam int CountBits = 8;
  localparam int XBits     = 60;
  localparam int ProdBits  = 115;
  localparam int AccBits   = 118;
  localparam int CarryBits = 64;
  localparam int NumLimbs  = 5;

  typedef struct packed {
    logic                 cmd;
    logic [OpBits-1:0]    a_limb0;
    logic [OpBits-1:0]    a_limb1;
    logic [OpBits-1:0]    a_limb2;
    logic [OpBits-1:0]    a_limb3;
    logic [OpBits-1:0]    a_limb4;
    logic [OpBits-1:0]    b_limb0;
    logic [OpBits-1:0]    b_limb1;
    logic [OpBits-1:0]    b_limb2;
    logic [OpBits-1:0]    b_limb3;
    logic [OpBits-1:0]    b_limb4;
    logic [CountBits-1:0] square_count;
  } req_t;

  typedef struct packed {
    logic [LimbBits-1:0] r_limb0;
    logic [LimbBits-1:0] r_limb1;
    logic [LimbBits:0]   r_limb2;
    logic [LimbBits-1:0] r_limb3;
    logic [LimbBits-1:0] r_limb4;
  } result_t;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDrain,
    StFold,
    StFin,
    StDone
  } state_e;

  localparam logic CmdMul    = 1'b0;
  localparam logic CmdSquare = 1'b1;

  typedef struct packed {
    logic       load;
    logic       issue;
    logic       first;
    logic       last;
    logic [2:0] col;
    logic [2:0] term;
    logic       fold;
    logic       fin;
  } ctrl_t;

  // limb of the second operand that pairs with limb term in column col (mod 5)
  function automatic logic [2:0] pair_idx(input logic [2:0] col, input logic [2:0] term);
    logic [2:0] r;
    if (term <= col) begin
      r = col - term;
    end else begin
      r = col + 3'd5 - term;
    end
    return r;
  endfunction

endpackage

>>> rtl/fmsq_ctrl.sv
// sequencer: issues the 25 limb products per multiply and runs the reduction steps
`timescale 1ns / 1ps
module fmsq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  cmd_i,
  input  logic [7:0]            square_count_i,
  input  logic                  pipe_busy_i,
  output fmsq_pkg::ctrl_t       ctrl_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import fmsq_pkg::*;

  state_e               state_q, state_d;
  logic [2:0]           col_q, term_q;
  logic [CountBits-1:0] cnt_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (start_i) state_d = StMul;
      StMul:   if (col_q == 3'd4 && term_q == 3'd4) state_d = StDrain;
      StDrain: if (!pipe_busy_i) state_d = StFold;
      StFold:  state_d = StFin;
      StFin:   state_d = (cnt_q == CountBits'(1)) ? StDone : StMul;
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    ctrl_o       = '0;
    ctrl_o.load  = (state_q == StIdle) && start_i;
    ctrl_o.issue = (state_q == StMul);
    ctrl_o.first = (term_q == 3'd0);
    ctrl_o.last  = (term_q == 3'd4);
    ctrl_o.col   = col_q;
    ctrl_o.term  = term_q;
    ctrl_o.fold  = (state_q == StFold);
    ctrl_o.fin   = (state_q == StFin);
    busy_o       = (state_q != StIdle);
    done_o       = (state_q == StDone);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      term_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && start_i) begin
        col_q  <= '0;
        term_q <= '0;
        // a zero square count runs once
        if (cmd_i == CmdSquare && square_count_i != '0) begin
          cnt_q <= square_count_i;
        end else begin
          cnt_q <= CountBits'(1);
        end
      end else if (state_q == StMul) begin
        if (term_q == 3'd4) begin
          term_q <= '0;
          col_q  <= col_q + 3'd1;
        end else begin
          term_q <= term_q + 3'd1;
        end
      end else if (state_q == StFin) begin
        cnt_q  <= cnt_q - CountBits'(1);
        col_q  <= '0;
        term_q <= '0;
      end
    end
  end

endmodule

>>> rtl/fmsq_dp.sv
// datapath: operand registers, split limb multiplier, column accumulator, carry fold
`timescale 1ns / 1ps
module fmsq_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fmsq_pkg::req_t    req_i,
  input  fmsq_pkg::ctrl_t   ctrl_i,
  output logic              pipe_busy_o,
  output fmsq_pkg::result_t result_o
);
  import fmsq_pkg::*;

  logic [OpBits-1:0]    x_q [NumLimbs];
  logic [OpBits-1:0]    y_q [NumLimbs];
  logic [LimbBits:0]    o_q [NumLimbs];
  logic [CarryBits-1:0] c_q, t_q;
  logic [AccBits-1:0]   acc_q;

  logic [57:0] ll_q, hl_q;
  logic [56:0] lh_q, hh_q;
  logic        s1_v_q, s1_first_q, s1_last_q;
  logic [2:0]  s1_col_q;
  logic [ProdBits-1:0] prod_q;
  logic        s2_v_q, s2_first_q, s2_last_q;
  logic [2:0]  s2_col_q;

  logic [OpBits-1:0]   xsel, ysel;
  logic [XBits-1:0]    xs;
  logic                wrap;
  logic [57:0]         ll_d, hl_d;
  logic [56:0]         lh_d, hh_d;
  logic [ProdBits-1:0] prod_d;
  logic [AccBits-1:0]  acc_d;
  logic [CarryBits-1:0] c19;
  logic [LimbBits:0]   r1s;
  logic [LimbBits:0]   r2;

  always_comb begin
    xsel = x_q[ctrl_i.term];
    ysel = y_q[pair_idx(ctrl_i.col, ctrl_i.term)];
    // columns at 2^255 and above fold back by 19
    wrap = ctrl_i.term > ctrl_i.col;
    if (wrap) begin
      xs = {1'b0, xsel, 4'b0} + {4'b0, xsel, 1'b0} + {5'b0, xsel};
    end else begin
      xs = {5'b0, xsel};
    end
    ll_d = xs[29:0] * ysel[27:0];
    lh_d = xs[29:0] * ysel[54:28];
    hl_d = xs[59:30] * ysel[27:0];
    hh_d = xs[59:30] * ysel[54:28];
    prod_d = {57'b0, ll_q} + {30'b0, lh_q, 28'b0} + {27'b0, hl_q, 30'b0} + {hh_q, 58'b0};
    // column starts from the carry of the previous column
    acc_d = (s2_first_q ? {54'b0, c_q} : acc_q) + {3'b0, prod_q};
    c19 = {c_q[59:0], 4'b0} + {c_q[62:0], 1'b0} + c_q;
    r1s = {1'b0, o_q[1][LimbBits-1:0]} + {39'b0, t_q[63:51]};
    r2  = {1'b0, o_q[2][LimbBits-1:0]} + {51'b0, r1s[LimbBits]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= ctrl_i.issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ll_q       <= ll_d;
    lh_q       <= lh_d;
    hl_q       <= hl_d;
    hh_q       <= hh_d;
    s1_first_q <= ctrl_i.first;
    s1_last_q  <= ctrl_i.last;
    s1_col_q   <= ctrl_i.col;
    prod_q     <= prod_d;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_col_q   <= s1_col_q;

    if (ctrl_i.load) begin
      x_q[0] <= req_i.a_limb0;
      x_q[1] <= req_i.a_limb1;
      x_q[2] <= req_i.a_limb2;
      x_q[3] <= req_i.a_limb3;
      x_q[4] <= req_i.a_limb4;
      if (req_i.cmd == CmdSquare) begin
        y_q[0] <= req_i.a_limb0;
        y_q[1] <= req_i.a_limb1;
        y_q[2] <= req_i.a_limb2;
        y_q[3] <= req_i.a_limb3;
        y_q[4] <= req_i.a_limb4;
      end else begin
        y_q[0] <= req_i.b_limb0;
        y_q[1] <= req_i.b_limb1;
        y_q[2] <= req_i.b_limb2;
        y_q[3] <= req_i.b_limb3;
        y_q[4] <= req_i.b_limb4;
      end
      c_q <= '0;
    end else if (ctrl_i.fin) begin
      x_q[0] <= {4'b0, t_q[LimbBits-1:0]};
      x_q[1] <= {4'b0, r1s[LimbBits-1:0]};
      x_q[2] <= {3'b0, r2};
      x_q[3] <= {3'b0, o_q[3]};
      x_q[4] <= {3'b0, o_q[4]};
      y_q[0] <= {4'b0, t_q[LimbBits-1:0]};
      y_q[1] <= {4'b0, r1s[LimbBits-1:0]};
      y_q[2] <= {3'b0, r2};
      y_q[3] <= {3'b0, o_q[3]};
      y_q[4] <= {3'b0, o_q[4]};
      o_q[0] <= {1'b0, t_q[LimbBits-1:0]};
      o_q[1] <= {1'b0, r1s[LimbBits-1:0]};
      o_q[2] <= r2;
      c_q    <= '0;
    end else if (ctrl_i.fold) begin
      t_q <= {13'b0, o_q[0][LimbBits-1:0]} + c19;
    end else if (s2_v_q) begin
      acc_q <= acc_d;
      if (s2_last_q) begin
        o_q[s2_col_q] <= {1'b0, acc_d[LimbBits-1:0]};
        c_q           <= acc_d[114:51];
      end
    end
  end

  assign pipe_busy_o = s1_v_q | s2_v_q;

  assign result_o.r_limb0 = o_q[0][LimbBits-1:0];
  assign result_o.r_limb1 = o_q[1][LimbBits-1:0];
  assign result_o.r_limb2 = o_q[2];
  assign result_o.r_limb3 = o_q[3][LimbBits-1:0];
  assign result_o.r_limb4 = o_q[4][LimbBits-1:0];

endmodule

>>> rtl/field_mul_square_p25519.sv
// top level of the p25519 field multiply / repeated square unit
`timescale 1ns / 1ps
// A request is taken when start_i is high and busy_o is low. A multiply
// runs its 25 limb products through one shared split multiplier, waits for
// the pipeline to drain, does the final carry fold and then raises the done_o
// strobe. A square request repeats these steps once per squaring (a count of
// zero means one) before the strobe. The result is on result_o from the single
// cycle that done_o is high until a new request overwrites it; the receiver
// cannot stall done_o, and busy_o stays high until that cycle is over.
module field_mul_square_p25519 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  fmsq_pkg::req_t    req_i,
  output logic              busy_o,
  output logic              done_o,
  output fmsq_pkg::result_t result_o
);
  import fmsq_pkg::*;

  ctrl_t ctrl;
  logic  pipe_busy;

  fmsq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .cmd_i          (req_i.cmd),
    .square_count_i (req_i.square_count),
    .pipe_busy_i    (pipe_busy),
    .ctrl_o         (ctrl),
    .busy_o         (busy_o),
    .done_o         (done_o)
  );

  fmsq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ctrl_i      (ctrl),
    .pipe_busy_o (pipe_busy),
    .result_o    (result_o)
  );

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("request taken but unit not busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("done strobe while idle");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  a_no_issue_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.fold || ctrl.fin) |-> !pipe_busy)
    else $error("carry fold while products in flight");

endmodule
